@@ rtl/core/pps_pkg.sv @@
// shared types and constants for the preemptive priority scheduler
package pps_pkg;

  localparam int MAX_PROCESSES_DEF = 64;
  localparam int TIME_W            = 24;

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // one process table record
  typedef struct packed {
    logic [7:0]        id;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [7:0]        prio;
    logic [15:0]       remaining;
    logic              started;
    logic [TIME_W-1:0] start_time;
  } entry_t;

endpackage

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// top level of the preemptive priority scheduler
//
// channel   | ports                                             | transfer
// ----------+---------------------------------------------------+--------------------------
// command   | start, action, proc_id, arrival_time, burst_time, | start high, busy low
//           | priority_level                                    |
// result    | strobe, add_refused, slot_idle, running_id,       | strobe high, one cycle,
//           | slot_time, finished, turnaround, waiting,          | cannot be held off
//           | response, all_done                                |
//
// add, clear and unknown commands stay in idle; the result strobes in the next cycle
// a tick with work left walks the table one entry per cycle through the ram read port,
//   then updates the picked entry, and adds turnaround, waiting and response steps when
//   the picked process finishes (they share one subtract unit)
// reset is synchronous; it empties the table and zeroes the clock, no clearing pass
// since the receiver cannot stall, busy only covers the tick scan and its update steps
module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  proc_id,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  priority_level,
  output logic        strobe,
  output logic        add_refused,
  output logic        slot_idle,
  output logic [7:0]  running_id,
  output logic [23:0] slot_time,
  output logic        finished,
  output logic [23:0] turnaround,
  output logic [23:0] waiting,
  output logic [23:0] response,
  output logic        all_done
);

  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int ENT_W = $bits(pps_pkg::entry_t);
  localparam int TW    = pps_pkg::TIME_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_TAT  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] done_count;
  logic [TW-1:0]    cur_time;
  logic [TW-1:0]    slot_t;      // time of the slot being worked on
  logic [CNT_W-1:0] addr_cnt;    // scan read pointer
  logic             cmp_vld;     // ram data valid for compare this cycle
  logic [IDX_W-1:0] cmp_idx;     // index that data belongs to
  logic             found;
  pps_pkg::entry_t  best;
  logic [IDX_W-1:0] best_idx;
  logic [TW-1:0]    tat_q;
  logic [TW-1:0]    wait_q;

  logic             accept;
  logic             full;
  logic [15:0]      burst_fix;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pps_pkg::entry_t  rd_entry;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pps_pkg::entry_t  wr_entry;
  pps_pkg::entry_t  new_entry;
  pps_pkg::entry_t  best_upd;
  logic             cand_ok;
  logic [TW-1:0]    sub_a;
  logic [TW-1:0]    sub_b;
  logic [TW-1:0]    sub_diff;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign full      = (entry_count >= CNT_W'(MAX_PROCESSES));
  // zero burst is stored as one
  assign burst_fix = (burst_time == 16'd0) ? 16'd1 : burst_time;

  // scan read port: one entry per cycle
  assign rd_en    = (state == S_SCAN) && (addr_cnt < entry_count);
  assign rd_addr  = addr_cnt[IDX_W-1:0];
  assign rd_entry = pps_pkg::entry_t'(rd_data);

  // arrived, unfinished, and strictly better priority keeps the lowest index on ties
  assign cand_ok = cmp_vld
                && (TW'(rd_entry.arrival) <= slot_t)
                && (rd_entry.remaining != 16'd0)
                && (!found || (rd_entry.prio < best.prio));

  // fresh record for an add
  always_comb begin
    new_entry            = '0;
    new_entry.id         = proc_id;
    new_entry.arrival    = arrival_time;
    new_entry.burst      = burst_fix;
    new_entry.prio       = priority_level;
    new_entry.remaining  = burst_fix;
    new_entry.started    = 1'b0;
    new_entry.start_time = '0;
  end

  // picked record after one unit of execution
  always_comb begin
    best_upd            = best;
    best_upd.remaining  = best.remaining - 16'd1;
    best_upd.started    = 1'b1;
    best_upd.start_time = best.started ? best.start_time : slot_t;
  end

  // write port: add in idle, write back of the picked entry in update
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = entry_count[IDX_W-1:0];
    wr_entry = new_entry;
    if (state == S_IDLE) begin
      wr_en = accept && (action == pps_pkg::ACT_ADD) && !full;
    end else if (state == S_UPD) begin
      wr_en    = found;
      wr_addr  = best_idx;
      wr_entry = best_upd;
    end
  end

  pps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PROCESSES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ENT_W'(wr_entry)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // operand selection for the shared subtract unit
  always_comb begin
    case (state)
      S_TAT: begin
        sub_a = cur_time;                 // already slot time + 1
        sub_b = TW'(best.arrival);
      end
      S_WAIT: begin
        sub_a = tat_q;
        sub_b = TW'(best.burst);
      end
      S_RESP: begin
        sub_a = best.start_time;
        sub_b = TW'(best.arrival);
      end
      default: begin
        sub_a = cur_time;
        sub_b = TW'(best.arrival);
      end
    endcase
  end

  pps_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      entry_count <= '0;
      done_count  <= '0;
      cur_time    <= '0;
      cmp_vld     <= 1'b0;
      found       <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      cmp_vld <= rd_en;
      cmp_idx <= rd_addr;
      case (state)
        S_IDLE: begin
          if (accept) begin
            // default result: everything zero
            add_refused <= 1'b0;
            slot_idle   <= 1'b0;
            running_id  <= '0;
            slot_time   <= '0;
            finished    <= 1'b0;
            turnaround  <= '0;
            waiting     <= '0;
            response    <= '0;
            all_done    <= 1'b0;
            slot_t      <= cur_time;
            case (action)
              pps_pkg::ACT_ADD: begin
                strobe      <= 1'b1;
                add_refused <= full;
                if (!full) begin
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              pps_pkg::ACT_CLEAR: begin
                strobe      <= 1'b1;
                entry_count <= '0;
                done_count  <= '0;
                cur_time    <= '0;
              end
              pps_pkg::ACT_TICK: begin
                if (done_count >= entry_count) begin
                  // nothing left: report all done, time holds
                  strobe    <= 1'b1;
                  slot_idle <= 1'b1;
                  slot_time <= cur_time;
                  all_done  <= 1'b1;
                end else begin
                  state    <= S_SCAN;
                  addr_cnt <= '0;
                  found    <= 1'b0;
                end
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            addr_cnt <= addr_cnt + CNT_W'(1);
          end
          if (cand_ok) begin
            best     <= rd_entry;
            best_idx <= cmp_idx;
            found    <= 1'b1;
          end
          // last entry compared this cycle
          if (cmp_vld && !rd_en) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          cur_time    <= slot_t + TW'(1);
          add_refused <= 1'b0;
          slot_time   <= slot_t;
          finished    <= 1'b0;
          turnaround  <= '0;
          waiting     <= '0;
          response    <= '0;
          all_done    <= (done_count >= entry_count);
          if (!found) begin
            strobe     <= 1'b1;
            slot_idle  <= 1'b1;
            running_id <= '0;
            state      <= S_IDLE;
          end else begin
            best       <= best_upd;
            slot_idle  <= 1'b0;
            running_id <= best.id;
            if (best_upd.remaining == 16'd0) begin
              state <= S_TAT;
            end else begin
              strobe <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        S_TAT: begin
          tat_q      <= sub_diff;
          done_count <= done_count + CNT_W'(1);
          state      <= S_WAIT;
        end
        S_WAIT: begin
          wait_q <= sub_diff;
          state  <= S_RESP;
        end
        S_RESP: begin
          strobe     <= 1'b1;
          finished   <= 1'b1;
          turnaround <= tat_q;
          waiting    <= wait_q;
          response   <= sub_diff;
          all_done   <= (done_count >= entry_count);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/pps_ram.sv @@
// generic single-write, single-read ram with registered read
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/pps_sub.sv @@
// shared modulo 2^24 subtract unit for the timing results
module pps_sub (
  input  logic [pps_pkg::TIME_W-1:0] a,
  input  logic [pps_pkg::TIME_W-1:0] b,
  output logic [pps_pkg::TIME_W-1:0] diff
);

  assign diff = a - b;

endmodule

@@ rtl/core/pps_checker.sv @@
// port-level checks for the preemptive priority scheduler, bound to the top level
module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        add_refused,
  input logic        slot_idle,
  input logic [7:0]  running_id,
  input logic        finished,
  input logic [23:0] turnaround,
  input logic [23:0] waiting,
  input logic [23:0] response,
  input logic        all_done
);

  // a result never shows while a command is still being worked on
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobe while busy");

  // an accepted command either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (strobe || busy))
    else $error("accepted command dropped");

  // idle slot has no owner and nothing finishes
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    (strobe && slot_idle) |-> (running_id == 8'd0 && !finished))
    else $error("idle slot reports an owner");

  // timing results only with a finished process
  a_timing_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !finished) |-> (turnaround == 24'd0 && waiting == 24'd0 &&
                               response == 24'd0))
    else $error("timing fields without finish");

  // a refused add carries no tick information
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && add_refused) |-> (!slot_idle && !all_done && !finished))
    else $error("refused add with tick fields");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

@@ dv/preemptive_priority_scheduler_unit_tb.sv @@
// self-checking testbench for the preemptive priority scheduler, with its own scheduling predictor
module preemptive_priority_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // the block gives no name to the fourth action code; it must be ignored
  localparam logic [1:0] ACT_RSVD = 2'd3;
  localparam int TBL_DEPTH = pps_pkg::MAX_PROCESSES_DEF;
  // longest tick: full table scan plus the finishing steps, with margin
  localparam int DRAIN_CYCLES = TBL_DEPTH + 16;
  localparam int ITEMS_PER_PHASE = 450;

  // one command as the driver presents it, with the sender idle rate of its phase
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    int          idle_pct;
  } cmd_t;

  // one slot report
  typedef struct packed {
    logic        add_refused;
    logic        slot_idle;
    logic [7:0]  running_id;
    logic [23:0] slot_time;
    logic        finished;
    logic [23:0] turnaround;
    logic [23:0] waiting;
    logic [23:0] response;
    logic        all_done;
  } slot_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = pps_pkg::ACT_CLEAR;
  logic [7:0]  proc_id = '0;
  logic [15:0] arrival_time = '0;
  logic [15:0] burst_time = '0;
  logic [7:0]  priority_level = '0;
  logic        busy;
  logic        strobe;
  logic        add_refused;
  logic        slot_idle;
  logic [7:0]  running_id;
  logic [23:0] slot_time;
  logic        finished;
  logic [23:0] turnaround;
  logic [23:0] waiting;
  logic [23:0] response;
  logic        all_done;

  preemptive_priority_scheduler_unit #(
    .MAX_PROCESSES(TBL_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .proc_id(proc_id),
    .arrival_time(arrival_time),
    .burst_time(burst_time),
    .priority_level(priority_level),
    .strobe(strobe),
    .add_refused(add_refused),
    .slot_idle(slot_idle),
    .running_id(running_id),
    .slot_time(slot_time),
    .finished(finished),
    .turnaround(turnaround),
    .waiting(waiting),
    .response(response),
    .all_done(all_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting to be driven, and slot reports waiting to come back
  cmd_t         job_q[$];
  slot_report_t slot_expect_q[$];
  logic         last_xfer = 1'b0;
  int           mismatch_count = 0;

  // tallies of what the run exercised
  int n_add = 0, n_refused = 0, n_clear = 0, n_rsvd = 0;
  int n_tick = 0, n_run = 0, n_finish = 0, n_idle = 0, n_all_done = 0;

  // predictor copy of the process table and the scheduler clock
  pps_pkg::entry_t sched_tbl [TBL_DEPTH];
  int              tbl_count = 0;
  int              fin_count = 0;
  logic [23:0]     now_tick = '0;

  // ---------------------------------------------------------------------------
  // scheduling predictor: applies one command to the table copy and returns the
  // slot report the block must produce for it
  // ---------------------------------------------------------------------------
  function automatic slot_report_t schedule_slot(cmd_t c);
    slot_report_t r;
    logic [23:0]  t;
    logic [23:0]  tat;
    int           pick;
    bit           found;
    r = '0;
    case (c.action)
      pps_pkg::ACT_ADD: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.add_refused = 1'b1;
        end else begin
          sched_tbl[tbl_count].id = c.proc_id;
          sched_tbl[tbl_count].arrival = c.arrival;
          // a zero burst is taken as one unit
          sched_tbl[tbl_count].burst = (c.burst == 16'd0) ? 16'd1 : c.burst;
          sched_tbl[tbl_count].prio = c.prio;
          sched_tbl[tbl_count].remaining = sched_tbl[tbl_count].burst;
          sched_tbl[tbl_count].started = 1'b0;
          sched_tbl[tbl_count].start_time = '0;
          tbl_count++;
        end
      end
      pps_pkg::ACT_CLEAR: begin
        tbl_count = 0;
        fin_count = 0;
        now_tick = '0;
      end
      pps_pkg::ACT_TICK: begin
        t = now_tick;
        r.slot_time = t;
        if (fin_count >= tbl_count) begin
          // nothing left to run: report all done, clock holds
          r.slot_idle = 1'b1;
          r.all_done = 1'b1;
        end else begin
          found = 1'b0;
          pick = 0;
          // lowest priority number wins, strict compare keeps the lowest index on ties
          for (int k = 0; k < tbl_count; k++) begin
            if ({8'd0, sched_tbl[k].arrival} <= t && sched_tbl[k].remaining != 16'd0) begin
              if (!found || sched_tbl[k].prio < sched_tbl[pick].prio) begin
                found = 1'b1;
                pick = k;
              end
            end
          end
          if (found) begin
            if (!sched_tbl[pick].started) begin
              sched_tbl[pick].started = 1'b1;
              sched_tbl[pick].start_time = t;
            end
            sched_tbl[pick].remaining = sched_tbl[pick].remaining - 16'd1;
            r.running_id = sched_tbl[pick].id;
            if (sched_tbl[pick].remaining == 16'd0) begin
              fin_count++;
              tat = t + 24'd1 - {8'd0, sched_tbl[pick].arrival};
              r.finished = 1'b1;
              r.turnaround = tat;
              r.waiting = tat - {8'd0, sched_tbl[pick].burst};
              r.response = sched_tbl[pick].start_time - {8'd0, sched_tbl[pick].arrival};
            end
          end else begin
            // table holds work but none of it has arrived yet
            r.slot_idle = 1'b1;
          end
          now_tick = t + 24'd1;
          r.all_done = (fin_count >= tbl_count);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string fname, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the next queued command at the falling edge and holds it
  // until a transfer is seen; idles at random at the rate of the item's phase
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !last_xfer) begin
      // command still waiting for busy to drop
    end else if (job_q.size() > 0 && $urandom_range(99) >= job_q[0].idle_pct) begin
      c = job_q.pop_front();
      start <= 1'b1;
      action <= c.action;
      proc_id <= c.proc_id;
      arrival_time <= c.arrival;
      burst_time <= c.burst;
      priority_level <= c.prio;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each strobed report against the oldest prediction, then
  // predicts for a command transferred at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    slot_report_t want;
    cmd_t         c;
    if (rst) begin
      last_xfer <= 1'b0;
    end else begin
      if (strobe) begin
        if (slot_expect_q.size() == 0) begin
          $display("%0t: report with none expected, actual running_id %0h slot_time %0h",
                   $time, running_id, slot_time);
          mismatch_count++;
        end else begin
          want = slot_expect_q.pop_front();
          check_field("add_refused", 24'(want.add_refused), 24'(add_refused));
          check_field("slot_idle", 24'(want.slot_idle), 24'(slot_idle));
          check_field("running_id", 24'(want.running_id), 24'(running_id));
          check_field("slot_time", want.slot_time, slot_time);
          check_field("finished", 24'(want.finished), 24'(finished));
          check_field("turnaround", want.turnaround, turnaround);
          check_field("waiting", want.waiting, waiting);
          check_field("response", want.response, response);
          check_field("all_done", 24'(want.all_done), 24'(all_done));
        end
      end
      if (start && !busy) begin
        c.action = action;
        c.proc_id = proc_id;
        c.arrival = arrival_time;
        c.burst = burst_time;
        c.prio = priority_level;
        c.idle_pct = 0;
        want = schedule_slot(c);
        slot_expect_q = {slot_expect_q, want};
        case (action)
          pps_pkg::ACT_ADD: begin
            n_add++;
            if (want.add_refused) n_refused++;
          end
          pps_pkg::ACT_CLEAR: n_clear++;
          pps_pkg::ACT_TICK: begin
            n_tick++;
            if (!want.slot_idle) n_run++;
            if (want.finished) n_finish++;
            if (want.slot_idle && !want.all_done) n_idle++;
            if (want.slot_idle && want.all_done) n_all_done++;
          end
          default: n_rsvd++;
        endcase
      end
      last_xfer <= start && !busy;
    end
  end

  task automatic push_cmd(logic [1:0] a, logic [7:0] id, logic [15:0] arr,
                          logic [15:0] bst, logic [7:0] pr, int pct);
    cmd_t c;
    c.action = a;
    c.proc_id = id;
    c.arrival = arr;
    c.burst = bst;
    c.prio = pr;
    c.idle_pct = pct;
    job_q = {job_q, c};
  endtask

  // one workload: optional clear, a batch of adds, then enough ticks to drain it;
  // some sets are cut short or get a late arrival added mid-run
  task automatic queue_job_set(int pct, bit big);
    int          n;
    int          max_arr;
    int          sum_burst;
    int          ticks;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0]  pr;
    n = big ? $urandom_range(66, 70) : $urandom_range(1, 10);
    if (big || $urandom_range(99) < 85) push_cmd(pps_pkg::ACT_CLEAR, 8'($urandom),
                                                 16'($urandom), 16'($urandom),
                                                 8'($urandom), pct);
    max_arr = 0;
    sum_burst = 0;
    for (int i = 0; i < n; i++) begin
      arr = big ? 16'($urandom_range(0, 8)) : 16'($urandom_range(0, 15));
      bst = big ? 16'($urandom_range(1, 2)) : 16'($urandom_range(1, 6));
      if ($urandom_range(99) < 5) bst = 16'd0;
      // narrow priorities half the time so ties and preemption are frequent
      pr = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      push_cmd(pps_pkg::ACT_ADD, 8'($urandom), arr, bst, pr, pct);
      if (int'(arr) > max_arr) max_arr = int'(arr);
      sum_burst += (bst == 16'd0) ? 1 : int'(bst);
    end
    ticks = max_arr + sum_burst + $urandom_range(0, 2);
    if ($urandom_range(99) < 15) ticks = $urandom_range(1, ticks);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(99) < 3)
        push_cmd(pps_pkg::ACT_ADD, 8'($urandom), 16'($urandom_range(0, 20)),
                 16'($urandom_range(1, 4)), 8'($urandom), pct);
      push_cmd(pps_pkg::ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
               8'($urandom), pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int phase_pct [4];
    int limit;
    // sender idle rates per phase; the third phase would stall the receiver,
    // which this interface cannot do, so it runs back to back
    phase_pct = '{0, 67, 0, 38};

    // directed part
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);  // empty table
    push_cmd(ACT_RSVD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0);           // unknown action
    push_cmd(pps_pkg::ACT_ADD, 8'hFF, 16'd2, 16'd0, 8'hFF, 0);         // zero burst
    push_cmd(pps_pkg::ACT_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00, 0);   // never arrives
    push_cmd(pps_pkg::ACT_ADD, 8'h5A, 16'd3, 16'd2, 8'h80, 0);
    push_cmd(pps_pkg::ACT_ADD, 8'hA5, 16'd3, 16'd1, 8'h80, 0);         // tie with the one above
    for (int i = 0; i < 7; i++)                                         // idle, runs, idle again
      push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);
    push_cmd(pps_pkg::ACT_CLEAR, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);  // empty after clear
    push_cmd(pps_pkg::ACT_ADD, 8'h01, 16'd0, 16'd1, 8'd1, 0);
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);  // finishes, all done
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);  // clock must hold
    push_cmd(pps_pkg::ACT_ADD, 8'h02, 16'd0, 16'd3, 8'd9, 0);
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);
    push_cmd(pps_pkg::ACT_ADD, 8'h03, 16'd0, 16'd1, 8'd3, 0);          // preempts the running one
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);
    push_cmd(pps_pkg::ACT_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 0);

    // random part, one workload after another, with loose noise commands between
    for (int p = 0; p < 4; p++) begin
      limit = job_q.size() + ITEMS_PER_PHASE;
      queue_job_set(phase_pct[p], p == 0);                      // overfills the table
      while (job_q.size() < limit) begin
        queue_job_set(phase_pct[p], $urandom_range(99) < 8);
        repeat ($urandom_range(0, 2))
          push_cmd(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom), phase_pct[p]);
      end
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // every command transferred, then every report back, then a settling margin
    while (job_q.size() > 0 || start) @(posedge clk);
    while (slot_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (slot_expect_q.size() > 0) begin
      $display("%0t: %0d reports never arrived", $time, slot_expect_q.size());
      mismatch_count++;
    end
    $display("covered %0d adds (%0d refused on a full table), %0d clears, %0d unknown commands",
             n_add, n_refused, n_clear, n_rsvd);
    $display("covered %0d ticks: %0d ran a process, %0d completions, %0d idle, %0d all done",
             n_tick, n_run, n_finish, n_idle, n_all_done);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("timeout with %0d commands and %0d reports outstanding",
             job_q.size(), slot_expect_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_sub.sv
rtl/core/preemptive_priority_scheduler_unit.sv
rtl/core/pps_checker.sv
dv/preemptive_priority_scheduler_unit_tb.sv
